// ===== hdl/rems_pkg.sv =====
// shared types and constants for the exposure mean score block
`default_nettype none

package rems_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 25;
    localparam int MEAN_W  = 18;
    localparam int Q_FRAC  = 8;
    localparam int LANES   = 3;

    // integer bits of the mean; a quotient at or above 2^MEAN_W saturates
    localparam int INT_W   = MEAN_W - Q_FRAC;
    localparam int CMP_W   = CNT_W + INT_W;
    localparam int STEP_W  = $clog2(MEAN_W);

    localparam logic [SUM_W-1:0]  SUM_MAX        = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_MAX      = {CNT_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX       = {MEAN_W{1'b1}};
    // 1000.0 in q10.8
    localparam logic [MEAN_W-1:0] LARGE_SCORE_Q8 = 18'd256000;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_red;
        logic [MEAN_W-1:0] mean_green;
        logic [MEAN_W-1:0] mean_blue;
        logic              no_coverage;
    } score_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] covered_count;
    } frame_sum_t;

endpackage

`default_nettype wire

// ===== hdl/rgb_exposure_mean_score_core.sv =====
// top level of the rgb exposure mean score block
//
// input channel: one pixel per transfer (push/full); pixel carries red, green,
// blue, alpha and last_pixel. pixels are taken one per cycle, back to back,
// while full is low
// every pixel adds its color bytes to three 32-bit sums; nonzero alpha bumps
// the covered count. the last pixel closes the frame and its summary goes
// into a small queue (QUEUE_DEPTH entries)
// result channel: one score per frame (empty/pop); means are sum*256/count in
// unsigned q10.8, saturated at 262143; with no covered pixel all three means
// are 1000.0 and no_coverage is set
// path from the last pixel's transfer to empty going low, when the divider is
// free: queue write, divider load, the 18-step restoring divider (one quotient bit
// per cycle, three lanes side by side), then the result register write
// pixels stream at one per cycle while full is low; the divider works on one
// frame at a time, so a run of very short frames fills the queue and raises
// full
// a stalled receiver holds the score in the result register; the divider
// finishes the next frame and waits, then the queue fills and full goes high
// reset clears sums, count, queue and the result valid flag; empty is high
`default_nettype none

module rgb_exposure_mean_score_core
    import rems_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    output logic        full,
    input  wire pixel_t pixel,
    output logic        empty,
    input  wire logic   pop,
    output score_t      score
);

    // front to queue
    logic       sum_push;
    frame_sum_t sum_wr;
    logic       queue_full;

    // queue to back
    logic       sum_valid;
    logic       sum_take;
    frame_sum_t sum_rd;

    rems_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pixel      (pixel),
        .queue_full (queue_full),
        .full       (full),
        .sum_push   (sum_push),
        .sum_out    (sum_wr)
    );

    rems_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sum_push),
        .wr_data (sum_wr),
        .rd_en   (sum_take),
        .rd_data (sum_rd),
        .q_full  (queue_full),
        .q_valid (sum_valid)
    );

    // divider and result register
    rems_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_in    (sum_rd),
        .sum_take  (sum_take),
        .empty     (empty),
        .pop       (pop),
        .score     (score)
    );

endmodule

`default_nettype wire

// ===== hdl/rems_front.sv =====
// pixel accumulator: channel sums and covered count, frame summary on the last pixel
`default_nettype none

module rems_front
    import rems_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire pixel_t     pixel,
    input  wire logic       queue_full,
    output logic            full,
    output logic            sum_push,
    output frame_sum_t      sum_out
);

    logic [SUM_W-1:0] sum_reg  [LANES];
    logic [SUM_W-1:0] sum_next [LANES];
    logic [SUM_W-1:0] add_val  [LANES];
    logic [SUM_W:0]   add_wide [LANES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_acc;
    logic             accept;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    assign add_val[0] = SUM_W'(pixel.red);
    assign add_val[1] = SUM_W'(pixel.green);
    assign add_val[2] = SUM_W'(pixel.blue);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            add_wide[l] = {1'b0, sum_reg[l]} + {1'b0, add_val[l]};
            sum_next[l] = sum_reg[l];
        end
        count_acc = count_reg;
        if (pixel.alpha != '0 && count_reg != COUNT_MAX)
        begin
            count_acc = count_reg + 1'b1;
        end
        count_next = count_reg;
        if (accept)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                // saturating add
                sum_next[l] = add_wide[l][SUM_W] ? SUM_MAX : add_wide[l][SUM_W-1:0];
            end
            count_next = count_acc;
            if (pixel.last_pixel)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    sum_next[l] = '0;
                end
                count_next = '0;
            end
        end
    end

    // summary carries the sums including the last pixel itself
    assign sum_push = accept && pixel.last_pixel;
    assign sum_out.sum_red       = add_wide[0][SUM_W] ? SUM_MAX : add_wide[0][SUM_W-1:0];
    assign sum_out.sum_green     = add_wide[1][SUM_W] ? SUM_MAX : add_wide[1][SUM_W-1:0];
    assign sum_out.sum_blue      = add_wide[2][SUM_W] ? SUM_MAX : add_wide[2][SUM_W-1:0];
    assign sum_out.covered_count = count_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                sum_reg[l] <= '0;
            end
            count_reg <= '0;
        end
        else
        begin
            for (int l = 0; l < LANES; l++)
            begin
                sum_reg[l] <= sum_next[l];
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rems_queue.sv =====
// short queue of frame summaries between accumulator and divider
`default_nettype none

module rems_queue
    import rems_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire frame_sum_t wr_data,
    input  wire logic       rd_en,
    output frame_sum_t      rd_data,
    output logic            q_full,
    output logic            q_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    frame_sum_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg;
    logic [CNT_QW-1:0] fill_next;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (fill_reg == CNT_QW'(DEPTH));
    assign q_valid = (fill_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rems_back.sv =====
// three-lane bit-serial divider with saturation and the result register
`default_nettype none

module rems_back
    import rems_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       sum_valid,
    input  wire frame_sum_t sum_in,
    output logic            sum_take,
    output logic            empty,
    input  wire logic       pop,
    output score_t          score
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  n_next;
    logic              zero_reg;
    logic              zero_next;
    logic [CNT_W-1:0]  rem_reg  [LANES];
    logic [CNT_W-1:0]  rem_next [LANES];
    logic [MEAN_W-1:0] low_reg  [LANES];
    logic [MEAN_W-1:0] low_next [LANES];
    logic [MEAN_W-1:0] q_reg    [LANES];
    logic [MEAN_W-1:0] q_next   [LANES];
    logic              sat_reg  [LANES];
    logic              sat_next [LANES];
    logic [SUM_W-1:0]  s_in     [LANES];
    logic [CNT_W:0]    trial    [LANES];
    logic [MEAN_W-1:0] mean_val [LANES];
    logic              out_valid_reg;
    logic              out_valid_next;
    score_t            score_reg;
    score_t            score_next;

    assign s_in[0] = sum_in.sum_red;
    assign s_in[1] = sum_in.sum_green;
    assign s_in[2] = sum_in.sum_blue;

    assign empty = !out_valid_reg;
    assign score = score_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        score_next     = score_reg;
        sum_take       = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            rem_next[l] = rem_reg[l];
            low_next[l] = low_reg[l];
            q_next[l]   = q_reg[l];
            sat_next[l] = sat_reg[l];
            trial[l]    = {rem_reg[l], low_reg[l][MEAN_W-1]};
            mean_val[l] = zero_reg ? LARGE_SCORE_Q8 : (sat_reg[l] ? MEAN_MAX : q_reg[l]);
        end
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sum_valid)
                begin
                    sum_take  = 1'b1;
                    n_next    = sum_in.covered_count;
                    zero_next = (sum_in.covered_count == '0);
                    step_next = '0;
                    for (int l = 0; l < LANES; l++)
                    begin
                        // quotient reaches 2^MEAN_W exactly when s >= n * 2^INT_W
                        sat_next[l] = CMP_W'(s_in[l]) >= {sum_in.covered_count, INT_W'(0)};
                        rem_next[l] = CNT_W'(s_in[l] >> INT_W);
                        low_next[l] = {s_in[l][INT_W-1:0], Q_FRAC'(0)};
                        q_next[l]   = '0;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    if (trial[l] >= {1'b0, n_reg})
                    begin
                        rem_next[l] = CNT_W'(trial[l] - {1'b0, n_reg});
                        q_next[l]   = {q_reg[l][MEAN_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = trial[l][CNT_W-1:0];
                        q_next[l]   = {q_reg[l][MEAN_W-2:0], 1'b0};
                    end
                    low_next[l] = {low_reg[l][MEAN_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MEAN_W - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || pop)
                begin
                    score_next.mean_red    = mean_val[0];
                    score_next.mean_green  = mean_val[1];
                    score_next.mean_blue   = mean_val[2];
                    score_next.no_coverage = zero_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        zero_reg  <= zero_next;
        score_reg <= score_next;
        step_reg  <= step_next;
        for (int l = 0; l < LANES; l++)
        begin
            rem_reg[l] <= rem_next[l];
            low_reg[l] <= low_next[l];
            q_reg[l]   <= q_next[l];
            sat_reg[l] <= sat_next[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rems_checker.sv =====
// port-level checker for the exposure mean score block, bound to the top level
`default_nettype none

module rems_checker
    import rems_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   push,
    input wire logic   full,
    input wire pixel_t pixel,
    input wire logic   empty,
    input wire logic   pop,
    input wire score_t score
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       frame_in;
    logic       score_out;

    assign frame_in  = push && !full && pixel.last_pixel;
    assign score_out = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg;
        if (frame_in && !score_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (score_out && !frame_in)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a score only for a frame already closed
    a_score_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != '0)
        else $error("score shown with no closed frame outstanding");

    // backpressure only when frames are waiting
    a_full_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> pending_reg != '0)
        else $error("full raised with no frame outstanding");

    a_no_coverage_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && score.no_coverage) |->
            (score.mean_red == LARGE_SCORE_Q8 && score.mean_green == LARGE_SCORE_Q8
             && score.mean_blue == LARGE_SCORE_Q8))
        else $error("no_coverage score without 1000.0 means");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(score)))
        else $error("stalled score changed or dropped");

endmodule

bind rgb_exposure_mean_score_core rems_checker u_rems_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .pixel (pixel),
    .empty (empty),
    .pop   (pop),
    .score (score)
);

`default_nettype wire

// ===== tb/sv/exposure_score_checker.sv =====
// scoreboard that predicts exposure mean scores and checks them against the block
module exposure_score_checker
    import rems_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  logic   full,
    input  pixel_t pixel,
    input  logic   empty,
    input  logic   pop,
    input  score_t score,
    output int     mismatches,
    output int     pending
);

    logic [SUM_W-1:0] red_total;
    logic [SUM_W-1:0] green_total;
    logic [SUM_W-1:0] blue_total;
    logic [CNT_W-1:0] covered;
    score_t           expected_scores[$];
    score_t           frame_score;
    score_t           want;
    int               errors = 0;

    function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] acc,
                                                     input logic [PIX_W-1:0] value);
        logic [SUM_W:0] total;
        total = {1'b0, acc} + value;
        return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    // sum * 256 / count, truncated, clipped to the q10.8 maximum
    function automatic logic [MEAN_W-1:0] channel_mean(input logic [SUM_W-1:0] total,
                                                       input logic [CNT_W-1:0] count);
        logic [SUM_W+Q_FRAC-1:0] quotient;
        quotient = {total, {Q_FRAC{1'b0}}} / count;
        return (quotient > MEAN_MAX) ? MEAN_MAX : quotient[MEAN_W-1:0];
    endfunction

    function automatic int field_check(input string name, input int unsigned expected_value,
                                       input int unsigned actual_value);
        if (expected_value == actual_value)
            return 0;
        $error("%s mismatch: expected %0d, actual %0d", name, expected_value, actual_value);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_total = '0;
            green_total = '0;
            blue_total = '0;
            covered = '0;
            expected_scores.delete();
        end
        else
        begin
            if (push && !full)
            begin
                red_total = add_clamped(red_total, pixel.red);
                green_total = add_clamped(green_total, pixel.green);
                blue_total = add_clamped(blue_total, pixel.blue);
                if (pixel.alpha != '0 && covered != COUNT_MAX)
                    covered = covered + 1'b1;
                if (pixel.last_pixel)
                begin
                    if (covered == '0)
                        frame_score = '{LARGE_SCORE_Q8, LARGE_SCORE_Q8, LARGE_SCORE_Q8, 1'b1};
                    else
                        frame_score = '{channel_mean(red_total, covered),
                                        channel_mean(green_total, covered),
                                        channel_mean(blue_total, covered), 1'b0};
                    expected_scores.push_back(frame_score);
                    red_total = '0;
                    green_total = '0;
                    blue_total = '0;
                    covered = '0;
                end
            end
            if (pop && !empty)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("score transfer with no frame waiting: %p", score);
                    errors++;
                end
                else
                begin
                    want = expected_scores.pop_front();
                    errors += field_check("mean_red", want.mean_red, score.mean_red);
                    errors += field_check("mean_green", want.mean_green, score.mean_green);
                    errors += field_check("mean_blue", want.mean_blue, score.mean_blue);
                    errors += field_check("no_coverage", want.no_coverage, score.no_coverage);
                end
            end
        end
        pending <= expected_scores.size();
        mismatches <= errors;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the exposure mean score testbench: clock, reset, pixel stimulus and verdict
module testbench;
    import rems_pkg::*;

    // cycles to let pass after the last score, longer than the divider latency
    localparam int LATENCY_WAIT  = 40;
    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    // how long the receiver holds off to force the block to fill up
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 1300;

    // flavors of random frame
    typedef enum int {
        FRAME_MIXED,      // random bytes, most pixels covered
        FRAME_UNCOVERED,  // alpha always zero, exercises the 1000.0 score
        FRAME_SPARSE,     // bright bytes, rare coverage, drives means into clipping
        FRAME_EXTREME     // bytes only at 0 or 255
    } frame_kind_e;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   push = 1'b0;
    logic   pop = 1'b0;
    pixel_t pixel = '0;
    logic   full;
    logic   empty;
    score_t score;
    int     mismatches;
    int     pending;

    // idle odds in percent for each side, changed per phase
    int     send_idle_pct = 14;
    int     take_idle_pct = 14;
    // raised by the stimulus, cleared by the receiver once its hold-off is over
    bit     hold_receiver = 1'b0;

    int     offered = 0;
    int     pixels_moved = 0;
    int     scores_moved = 0;
    int     uncovered_scores = 0;
    int     clipped_scores = 0;
    int     quiet_cycles = 0;

    always #5 clk = ~clk;

    rgb_exposure_mean_score_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pixel (pixel),
        .empty (empty),
        .pop   (pop),
        .score (score)
    );

    exposure_score_checker score_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .empty      (empty),
        .pop        (pop),
        .score      (score),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // transfer bookkeeping for the summary, plus the hang watchdog
    always @(posedge clk)
    begin
        if (push && !full)
            pixels_moved++;
        if (pop && !empty)
        begin
            scores_moved++;
            if (score.no_coverage)
                uncovered_scores++;
            else if (score.mean_red == MEAN_MAX || score.mean_green == MEAN_MAX
                     || score.mean_blue == MEAN_MAX)
                clipped_scores++;
        end
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: pops at random, with one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_receiver = 1'b0;
            end
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // one pixel transfer; idle cycles are inserted before the pixel is offered,
    // so push never drops and rises within the same step
    task automatic offer_pixel(input pixel_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        offered++;
    endtask

    task automatic offer_rgba(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic last);
        pixel_t p;
        p = '{r, g, b, a, last};
        offer_pixel(p);
    endtask

    // a whole frame of random pixels, the final one marked last
    task automatic offer_frame(input int len, input frame_kind_e kind);
        pixel_t p;
        for (int i = 0; i < len; i++)
        begin
            p.red = 8'($urandom);
            p.green = 8'($urandom);
            p.blue = 8'($urandom);
            case (kind)
                FRAME_MIXED:
                    p.alpha = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(1, 255));
                FRAME_UNCOVERED:
                    p.alpha = 8'd0;
                FRAME_SPARSE:
                begin
                    p.red = 8'($urandom_range(192, 255));
                    p.green = 8'($urandom_range(192, 255));
                    p.blue = 8'($urandom_range(192, 255));
                    p.alpha = ($urandom_range(99) < 8) ? 8'($urandom_range(1, 255)) : 8'd0;
                end
                default:
                begin
                    p.red = $urandom_range(1) ? 8'hFF : 8'h00;
                    p.green = $urandom_range(1) ? 8'hFF : 8'h00;
                    p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
                    p.alpha = $urandom_range(1) ? 8'hFF : 8'h00;
                end
            endcase
            p.last_pixel = (i == len - 1);
            offer_pixel(p);
        end
    endtask

    // mostly short frames, a few long ones
    function automatic int random_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return $urandom_range(1, 12);
        else if (roll < 95)
            return $urandom_range(13, 64);
        else
            return $urandom_range(65, 300);
    endfunction

    function automatic frame_kind_e random_kind();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return FRAME_MIXED;
        else if (roll < 70)
            return FRAME_UNCOVERED;
        else if (roll < 85)
            return FRAME_SPARSE;
        else
            return FRAME_EXTREME;
    endfunction

    // stop offering and wait for every predicted score to come out
    task automatic drain_scores();
        @(negedge clk);
        push <= 1'b0;
        wait (pending == 0);
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // single uncovered pixel: 1000.0 and the no-coverage flag
        offer_rgba(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        // single full-scale covered pixel
        offer_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        // uncovered pixel then a covered one with alpha of one
        offer_rgba(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        offer_rgba(8'd255, 8'd128, 8'd1, 8'd1, 1'b1);
        // uncovered bright pixels pile up over one covered pixel: all means clip
        repeat (4) offer_rgba(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
        offer_rgba(8'd255, 8'd255, 8'd255, 8'd128, 1'b1);
        // only red clips, green stays zero, blue lands mid-range
        repeat (4) offer_rgba(8'd255, 8'd0, 8'd100, 8'd0, 1'b0);
        offer_rgba(8'd255, 8'd0, 8'd100, 8'd1, 1'b1);
        // division that truncates
        offer_rgba(8'd1, 8'd2, 8'd3, 8'd1, 1'b0);
        offer_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
        offer_rgba(8'd0, 8'd0, 8'd0, 8'd7, 1'b1);
        // nonzero sums but nothing covered
        offer_rgba(8'd200, 8'd100, 8'd50, 8'd0, 1'b0);
        offer_rgba(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
        // red mean just under the clipping point
        repeat (4) offer_rgba(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
        offer_rgba(8'd3, 8'd0, 8'd0, 8'd1, 1'b1);

        // random frames with random idling on both sides
        while (offered < 424)
            offer_frame(random_length(), random_kind());

        // stretch with no idling on either side
        send_idle_pct = 0;
        take_idle_pct = 0;
        while (offered < 800)
            offer_frame(random_length(), random_kind());
        send_idle_pct = 14;
        take_idle_pct = 14;

        // receiver holds off while one-pixel frames keep coming: the summary
        // queue fills and full must hold the sender back
        hold_receiver = 1'b1;
        repeat (24)
            offer_frame(1, random_kind());

        // sender pauses until the block has handed out every score
        drain_scores();

        while (offered < 24 + RANDOM_PIXELS)
            offer_frame(random_length(), random_kind());

        drain_scores();
        repeat (LATENCY_WAIT) @(posedge clk);

        $display("%0d pixels in %0d frames, %0d frames with no coverage, %0d with a clipped mean",
                 pixels_moved, scores_moved, uncovered_scores, clipped_scores);
        $display("includes a %0d-cycle receiver hold-off and a no-idle stretch", HOLD_CYCLES);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
